// ===== sv/cascading_prescaled_timers_defines.svh =====
// Assertion macros shared by the timer block's checker.
// Depends on nothing; the including scope must provide clk_i and rst_ni.
`ifndef CASCADING_PRESCALED_TIMERS_DEFINES_SVH
`define CASCADING_PRESCALED_TIMERS_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CPT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timer check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define CPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timer check failed");

`endif

// ===== sv/cpt_pkg.sv =====
// Shared types and constants for the cascading prescaled timer block.
// No dependencies.
package cpt_pkg;

  localparam int unsigned NumTimers = 4;
  localparam int unsigned AccWidth  = 11;
  localparam int unsigned CycWidth  = 4;
  localparam int unsigned CtlWidth  = 8;
  localparam int unsigned IdxWidth  = 2;
  localparam int unsigned RegIdxWidth = 3;
  localparam int unsigned DataWidth = 16;
  localparam int unsigned WrapsOutWidth = 4;

  // Control register bit positions
  localparam int unsigned CtlCascadeBit = 2;
  localparam int unsigned CtlIrqBit     = 6;
  localparam int unsigned CtlEnableBit  = 7;

  // Register indexes
  localparam logic [RegIdxWidth-1:0] RegT0Control = 3'd0;
  localparam logic [RegIdxWidth-1:0] RegT0Reload  = 3'd4;

  // Prescaler select codes
  localparam logic [1:0] PrescDiv1    = 2'd0;
  localparam logic [1:0] PrescDiv64   = 2'd1;
  localparam logic [1:0] PrescDiv256  = 2'd2;
  localparam logic [1:0] PrescDiv1024 = 2'd3;

  typedef logic [AccWidth-1:0] acc_t;

  typedef struct packed {
    acc_t n;      // whole prescale periods elapsed
    acc_t rest;   // accumulator left over
  } presc_res_t;

  function automatic logic [3:0] presc_shift(input logic [1:0] sel);
    logic [3:0] sh;
    unique case (sel)
      PrescDiv1:    sh = 4'd0;
      PrescDiv64:   sh = 4'd6;
      PrescDiv256:  sh = 4'd8;
      PrescDiv1024: sh = 4'd10;
      default:      sh = 4'd0;
    endcase
    return sh;
  endfunction

endpackage

// ===== sv/cpt_presc.sv =====
// Prescale accumulator update: adds elapsed cycles and splits into periods.
// Depends on cpt_pkg.
module cpt_presc (
  input  cpt_pkg::acc_t                     acc_i,
  input  logic [cpt_pkg::CycWidth-1:0]      cycles_i,
  input  logic [1:0]                        sel_i,
  output cpt_pkg::presc_res_t               res_o
);

  logic [cpt_pkg::AccWidth:0] sum;
  cpt_pkg::acc_t              acc_wrap;
  logic [3:0]                 sh;
  cpt_pkg::acc_t              mask;

  assign sum      = {1'b0, acc_i} + (cpt_pkg::AccWidth + 1)'(cycles_i);
  assign acc_wrap = sum[cpt_pkg::AccWidth-1:0];
  assign sh       = cpt_pkg::presc_shift(sel_i);
  assign mask     = (cpt_pkg::acc_t'(1) << sh) - cpt_pkg::acc_t'(1);

  always_comb begin
    res_o.n    = acc_wrap >> sh;
    res_o.rest = acc_wrap & mask;
  end

endmodule

// ===== sv/cpt_step.sv =====
// Shared single-increment unit: counter plus one, reload on wrap to zero.
// No package dependency.
module cpt_step #(
  parameter int unsigned CounterWidth = 16
) (
  input  logic [CounterWidth-1:0] count_i,
  input  logic [CounterWidth-1:0] reload_i,
  output logic [CounterWidth-1:0] next_o,
  output logic                    wrap_o
);

  assign wrap_o = &count_i;
  assign next_o = wrap_o ? reload_i : count_i + CounterWidth'(1);

endmodule

// ===== sv/cascading_prescaled_timers.sv =====
// Four cascadable prescaled up-counting timers, top level.
// Depends on cpt_pkg, cpt_presc and cpt_step.
// Usage:
//   Input channel (in_valid_i / in_stall_o / elapsed_cycles_i): one transaction
//   per tick, carrying the clock cycles elapsed since the previous tick.
//   Output channel (out_valid_o / out_stall_i / count*_o, wraps*_o, irq_flags_o):
//   one transaction per tick with each counter after the tick, the overflow
//   count of each timer (saturated at 15) and the irq flags.
//   Config port (cfg_we_i, cfg_index_i, cfg_data_i): indexes 0-3 are the
//   control registers, 4-7 the reload values; write only while idle.
// Sequencing: the timers are processed in order 0 to 3 by one shared increment
//   unit. For each timer i a load state picks n_i, its increment count in
//   this tick (prescaled periods, or overflows of timer i-1 in cascade); the
//   step state then applies the n_i increments and closes the timer. A new
//   tick is taken only after the previous result has entered the output
//   register. n_i reaches 1038 only when the prescaler is lowered mid-count.
// Stall: in_stall_o is high while a tick is processed. A finished result waits
//   in the output register; the next tick is accepted meanwhile, and its
//   result waits until the earlier one has been taken.
// Reset: counters, accumulators, config and sequencer registers clear to zero; no result pending.
module cascading_prescaled_timers #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [cpt_pkg::CycWidth-1:0]         elapsed_cycles_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [cpt_pkg::DataWidth-1:0]        count0_o,
  output logic [cpt_pkg::DataWidth-1:0]        count1_o,
  output logic [cpt_pkg::DataWidth-1:0]        count2_o,
  output logic [cpt_pkg::DataWidth-1:0]        count3_o,
  output logic [cpt_pkg::WrapsOutWidth-1:0]    wraps0_o,
  output logic [cpt_pkg::WrapsOutWidth-1:0]    wraps1_o,
  output logic [cpt_pkg::WrapsOutWidth-1:0]    wraps2_o,
  output logic [cpt_pkg::WrapsOutWidth-1:0]    wraps3_o,
  output logic [cpt_pkg::NumTimers-1:0]        irq_flags_o,
  input  logic                                 cfg_we_i,
  input  logic [cpt_pkg::RegIdxWidth-1:0]      cfg_index_i,
  input  logic [cpt_pkg::DataWidth-1:0]        cfg_data_i
);

  localparam int unsigned CW = COUNTER_WIDTH;
  localparam int unsigned NT = cpt_pkg::NumTimers;
  localparam int unsigned WO = cpt_pkg::WrapsOutWidth;

  // Sequencer states
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLoad = 2'd1;
  localparam logic [1:0] StStep = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  localparam logic [cpt_pkg::IdxWidth-1:0] LastIdx = cpt_pkg::IdxWidth'(NT - 1);
  localparam cpt_pkg::acc_t WrapsSat = cpt_pkg::acc_t'((1 << WO) - 1);

  // Configuration registers
  logic [cpt_pkg::CtlWidth-1:0] ctl_q    [NT];
  logic [CW-1:0]                reload_q [NT];

  // Timer state
  logic [CW-1:0]   cnt_q [NT];
  cpt_pkg::acc_t   acc_q [NT];

  // Sequencer registers
  logic [1:0]                      state_q;
  logic [cpt_pkg::IdxWidth-1:0]    idx_q;
  logic [cpt_pkg::CycWidth-1:0]    cyc_q;
  cpt_pkg::acc_t                   rem_q;
  cpt_pkg::acc_t                   wr_q;
  cpt_pkg::acc_t                   carry_q;
  logic [WO-1:0]                   wsat_q [NT];
  logic [NT-1:0]                   irq_q;

  // Output register
  logic                            out_valid_q;
  logic [cpt_pkg::DataWidth-1:0]   out_cnt_q  [NT];
  logic [WO-1:0]                   out_wr_q   [NT];
  logic [NT-1:0]                   out_irq_q;

  logic [cpt_pkg::CtlWidth-1:0] ctl_cur;
  logic                         en_cur;
  logic                         casc_cur;
  cpt_pkg::presc_res_t          presc_res;
  logic [CW-1:0]                step_next;
  logic                         step_wrap;
  logic                         in_fire;
  logic                         out_load;

  assign ctl_cur  = ctl_q[idx_q];
  assign en_cur   = ctl_cur[cpt_pkg::CtlEnableBit];
  assign casc_cur = ctl_cur[cpt_pkg::CtlCascadeBit] && (idx_q != '0);
  assign in_fire  = in_valid_i && (state_q == StIdle);
  assign out_load = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  cpt_presc u_presc (
    .acc_i    (acc_q[idx_q]),
    .cycles_i (cyc_q),
    .sel_i    (ctl_cur[1:0]),
    .res_o    (presc_res)
  );

  cpt_step #(
    .CounterWidth (CW)
  ) u_step (
    .count_i  (cnt_q[idx_q]),
    .reload_i (reload_q[idx_q]),
    .next_o   (step_next),
    .wrap_o   (step_wrap)
  );

  // Register writes; only bits the timers use matter, keep the byte anyway
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NT; i++) begin
        ctl_q[i]    <= '0;
        reload_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i < cpt_pkg::RegT0Reload) begin
        ctl_q[cfg_index_i[cpt_pkg::IdxWidth-1:0]] <=
          cfg_data_i[cpt_pkg::CtlWidth-1:0];
      end else begin
        reload_q[cfg_index_i[cpt_pkg::IdxWidth-1:0]] <= cfg_data_i[CW-1:0];
      end
    end
  end

  // Sequencer: walk timers 0..3, one increment per cycle in StStep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      cyc_q   <= '0;
      rem_q   <= '0;
      wr_q    <= '0;
      carry_q <= '0;
      irq_q   <= '0;
      for (int i = 0; i < NT; i++) begin
        cnt_q[i]  <= '0;
        acc_q[i]  <= '0;
        wsat_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            cyc_q   <= elapsed_cycles_i;
            idx_q   <= '0;
            carry_q <= '0;
            state_q <= StLoad;
          end
        end
        StLoad: begin
          // Pick the increment source for this timer
          wr_q <= '0;
          if (en_cur && casc_cur) begin
            rem_q <= carry_q;
          end else if (en_cur) begin
            rem_q        <= presc_res.n;
            acc_q[idx_q] <= presc_res.rest;
          end else begin
            rem_q <= '0;
          end
          state_q <= StStep;
        end
        StStep: begin
          if (rem_q != '0) begin
            cnt_q[idx_q] <= step_next;
            rem_q        <= rem_q - cpt_pkg::acc_t'(1);
            wr_q         <= wr_q + cpt_pkg::acc_t'(step_wrap);
          end else begin
            // Close this timer; the full overflow count feeds the next one
            wsat_q[idx_q] <= (wr_q > WrapsSat) ? WrapsSat[WO-1:0] : wr_q[WO-1:0];
            irq_q[idx_q]  <= (wr_q != '0) && ctl_cur[cpt_pkg::CtlIrqBit];
            carry_q       <= wr_q;
            if (idx_q == LastIdx) begin
              state_q <= StDone;
            end else begin
              idx_q   <= idx_q + cpt_pkg::IdxWidth'(1);
              state_q <= StLoad;
            end
          end
        end
        StDone: begin
          if (out_load) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int i = 0; i < NT; i++) begin
        out_cnt_q[i] <= cpt_pkg::DataWidth'(cnt_q[i]);
        out_wr_q[i]  <= wsat_q[i];
      end
      out_irq_q <= irq_q;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign count0_o    = out_cnt_q[0];
  assign count1_o    = out_cnt_q[1];
  assign count2_o    = out_cnt_q[2];
  assign count3_o    = out_cnt_q[3];
  assign wraps0_o    = out_wr_q[0];
  assign wraps1_o    = out_wr_q[1];
  assign wraps2_o    = out_wr_q[2];
  assign wraps3_o    = out_wr_q[3];
  assign irq_flags_o = out_irq_q;

endmodule

// ===== sv/cpt_checker.sv =====
// Port-level checks for the cascading prescaled timer block, and its bind.
// Depends on cpt_pkg and cascading_prescaled_timers_defines.svh.
`include "cascading_prescaled_timers_defines.svh"

module cpt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [cpt_pkg::DataWidth-1:0]     count0_o,
  input logic [cpt_pkg::WrapsOutWidth-1:0] wraps0_o,
  input logic [cpt_pkg::NumTimers-1:0]     irq_flags_o
);

  // A stalled result stays valid and holds its timer-0 count
  `CPT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(count0_o))

  // An accepted tick keeps the block busy in the next cycle
  `CPT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // A new result only comes out of a busy sequencer
  `CPT_ASSERT_NOW(a_result_from_busy, $rose(out_valid_o), $past(in_stall_o))

  // No timer-0 irq flag without an overflow of timer 0
  `CPT_ASSERT_NOW(a_irq_needs_wrap, out_valid_o && (wraps0_o == '0), !irq_flags_o[0])

endmodule

bind cascading_prescaled_timers cpt_checker u_cpt_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for cascading_prescaled_timers: tick transactions in,
// per-tick counter, overflow and irq results out, checked against a predictor.
// Depends on cpt_pkg and the cascading_prescaled_timers RTL only.
module tb;

  // Control register bits
  localparam logic [cpt_pkg::CtlWidth-1:0] CtlEn   =
    cpt_pkg::CtlWidth'(1) << cpt_pkg::CtlEnableBit;
  localparam logic [cpt_pkg::CtlWidth-1:0] CtlCasc =
    cpt_pkg::CtlWidth'(1) << cpt_pkg::CtlCascadeBit;
  localparam logic [cpt_pkg::CtlWidth-1:0] CtlIrq  =
    cpt_pkg::CtlWidth'(1) << cpt_pkg::CtlIrqBit;

  localparam int unsigned RandomItems = 400;
  // Cycles to let pass once nothing is pending.
  localparam int unsigned IdleSlack   = 40;
  // A hang guard only, set above the slowest legal run (ticks draining a full
  // prescaler leftover through all four timers, plus the ~4400-tick warm-up).
  localparam int unsigned CycleLimit  = 10_000_000;

  typedef struct packed {
    logic [cpt_pkg::NumTimers-1:0][cpt_pkg::DataWidth-1:0]     count;
    logic [cpt_pkg::NumTimers-1:0][cpt_pkg::WrapsOutWidth-1:0] wraps;
    logic [cpt_pkg::NumTimers-1:0]                             irq;
  } tick_result_t;

  // Predicts each tick's result and holds the results still to arrive.
  class timer_scoreboard;
    logic [cpt_pkg::CtlWidth-1:0]  ctl    [cpt_pkg::NumTimers];
    logic [cpt_pkg::DataWidth-1:0] reload [cpt_pkg::NumTimers];
    logic [cpt_pkg::DataWidth-1:0] count  [cpt_pkg::NumTimers];
    cpt_pkg::acc_t                 accum  [cpt_pkg::NumTimers];
    logic [cpt_pkg::NumTimers-1:0] ever_wrapped;
    tick_result_t                  expected_q [$];
    int unsigned                   mismatches;
    int unsigned                   checked;

    function new();
      for (int t = 0; t < cpt_pkg::NumTimers; t++) begin
        ctl[t] = '0;
        reload[t] = '0;
        count[t] = '0;
        accum[t] = '0;
      end
      ever_wrapped = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [cpt_pkg::RegIdxWidth-1:0] idx,
                          logic [cpt_pkg::DataWidth-1:0] data);
      if (idx < cpt_pkg::RegT0Reload)
        ctl[idx[cpt_pkg::IdxWidth-1:0]] = data[cpt_pkg::CtlWidth-1:0];
      else
        reload[idx[cpt_pkg::IdxWidth-1:0]] = data;
    endfunction

    function int unsigned period(logic [1:0] sel);
      case (sel)
        cpt_pkg::PrescDiv1:   return 1;
        cpt_pkg::PrescDiv64:  return 64;
        cpt_pkg::PrescDiv256: return 256;
        default:              return 1024;
      endcase
    endfunction

    // Step timer t by n increments; return its overflow count.
    function int unsigned bump(int t, int unsigned n);
      int unsigned w;
      logic [cpt_pkg::DataWidth-1:0] c;
      w = 0;
      c = count[t];
      repeat (n) begin
        c = c + 1'b1;
        if (c == '0) begin
          c = reload[t];
          w++;
        end
      end
      count[t] = c;
      if (w != 0) ever_wrapped[t] = 1'b1;
      return w;
    endfunction

    function void note_tick(logic [cpt_pkg::CycWidth-1:0] cyc);
      tick_result_t want;
      int unsigned carry, n, w, span;
      cpt_pkg::acc_t acc;
      int t;
      want = '0;
      carry = 0;
      for (t = 0; t < cpt_pkg::NumTimers; t++) begin
        w = 0;
        if (ctl[t][cpt_pkg::CtlEnableBit]) begin
          // Timer 0 ignores its cascade bit; a cascaded timer leaves its
          // accumulator alone.
          if (t > 0 && ctl[t][cpt_pkg::CtlCascadeBit]) begin
            n = carry;
          end else begin
            span = period(ctl[t][1:0]);
            acc = accum[t] + cpt_pkg::acc_t'(cyc);
            n = acc / span;
            accum[t] = cpt_pkg::acc_t'(acc - n * span);
          end
          w = bump(t, n);
          if (w != 0 && ctl[t][cpt_pkg::CtlIrqBit]) want.irq[t] = 1'b1;
        end
        want.wraps[t] = (w >= (1 << cpt_pkg::WrapsOutWidth)) ? '1 :
                        cpt_pkg::WrapsOutWidth'(w);
        want.count[t] = count[t];
        carry = w;
      end
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      if (mismatches < 50)
        $display("MISMATCH result %0d %s: got %0h expected %0h", checked, what, got, want);
      mismatches++;
    endtask

    task check_tick(tick_result_t got);
      tick_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
        return;
      end
      want = expected_q.pop_front();
      for (int t = 0; t < cpt_pkg::NumTimers; t++) begin
        if (got.count[t] !== want.count[t])
          report_mismatch($sformatf("count%0d", t), 32'(got.count[t]), 32'(want.count[t]));
        if (got.wraps[t] !== want.wraps[t])
          report_mismatch($sformatf("wraps%0d", t), 32'(got.wraps[t]), 32'(want.wraps[t]));
      end
      if (got.irq !== want.irq)
        report_mismatch("irq_flags", 32'(got.irq), 32'(want.irq));
      checked++;
    endtask
  endclass

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_stall_o;
  logic [cpt_pkg::CycWidth-1:0]         elapsed_cycles_i = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic [cpt_pkg::DataWidth-1:0]        count0_o, count1_o, count2_o, count3_o;
  logic [cpt_pkg::WrapsOutWidth-1:0]    wraps0_o, wraps1_o, wraps2_o, wraps3_o;
  logic [cpt_pkg::NumTimers-1:0]        irq_flags_o;
  logic                                 cfg_we_i = 1'b0;
  logic [cpt_pkg::RegIdxWidth-1:0]      cfg_index_i = '0;
  logic [cpt_pkg::DataWidth-1:0]        cfg_data_i = '0;

  timer_scoreboard sb = new();

  // Set per phase: when high, neither side inserts idle cycles.
  bit quiet = 1'b0;
  int unsigned cycle_count = 0;

  logic [cpt_pkg::CtlWidth-1:0]  plan_ctl    [cpt_pkg::NumTimers];
  logic [cpt_pkg::DataWidth-1:0] plan_reload [cpt_pkg::NumTimers];

  cascading_prescaled_timers dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hang guard: end the run if the limit is reached.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // All tasks below start and end at a falling edge.

  // Offer one tick transaction after a random gap; note it once accepted.
  task automatic send_tick(input logic [cpt_pkg::CycWidth-1:0] cyc);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    elapsed_cycles_i <= cyc;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_tick(cyc);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every pending result, then let the block go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (IdleSlack) @(negedge clk_i);
  endtask

  // Leaves the write enable high; load_plan lowers it after the last write.
  task automatic write_reg(input logic [cpt_pkg::RegIdxWidth-1:0] idx,
                           input logic [cpt_pkg::DataWidth-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  function automatic void plan(int t, logic [cpt_pkg::CtlWidth-1:0] c,
                               logic [cpt_pkg::DataWidth-1:0] r);
    plan_ctl[t] = c;
    plan_reload[t] = r;
  endfunction

  // Drain the block, then write all eight registers from the plan. The upper
  // byte of a control write is junk that the block must ignore.
  task automatic load_plan();
    settle();
    for (int t = 0; t < cpt_pkg::NumTimers; t++) begin
      write_reg(cpt_pkg::RegIdxWidth'(cpt_pkg::RegT0Control + t),
                {8'($urandom), plan_ctl[t]});
      write_reg(cpt_pkg::RegIdxWidth'(cpt_pkg::RegT0Reload + t), plan_reload[t]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Result side: hold stall for a random count, then take one transaction
  // and check it against the oldest prediction.
  initial begin
    tick_result_t got;
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = quiet ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.count[0] = count0_o;
      got.count[1] = count1_o;
      got.count[2] = count2_o;
      got.count[3] = count3_o;
      got.wraps[0] = wraps0_o;
      got.wraps[1] = wraps1_o;
      got.wraps[2] = wraps2_o;
      got.wraps[3] = wraps3_o;
      got.irq = irq_flags_o;
      sb.check_tick(got);
    end
  end

  initial begin
    int unsigned random_sent, n;
    logic [cpt_pkg::CtlWidth-1:0] c;
    logic [cpt_pkg::DataWidth-1:0] r;
    bit any_reload;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Out of reset every timer is disabled: counters must hold.
    send_tick(4'd0);
    send_tick(4'd15);

    // Timer 1 disabled with cascade set, timer 2 cascading from it (gets
    // nothing); timers 0 and 3 build up prescaler leftovers.
    plan(0, CtlEn | cpt_pkg::PrescDiv64, 16'h0000);
    plan(1, CtlCasc | cpt_pkg::PrescDiv1, 16'hFFFF);
    plan(2, CtlEn | CtlCasc | CtlIrq, 16'h0000);
    plan(3, CtlEn | cpt_pkg::PrescDiv256, 16'hFFFF);
    load_plan();
    repeat (4) send_tick(4'd15);

    // Lower the prescalers: timer 0 spends its whole leftover in one tick, timer 3 part of it.
    plan(0, CtlEn | cpt_pkg::PrescDiv1, 16'h0000);
    plan(3, CtlEn | cpt_pkg::PrescDiv64, 16'hFFFF);
    load_plan();
    send_tick(4'd15);
    send_tick(4'd0);

    // Warm-up: count all timers up at full rate until each has wrapped once,
    // so that reloads near the top make overflows frequent from here on.
    plan(0, CtlEn | cpt_pkg::PrescDiv1, 16'hFFFF);
    plan(1, CtlEn | cpt_pkg::PrescDiv1, 16'hFFFF);
    plan(2, CtlEn | cpt_pkg::PrescDiv1, 16'hFFF0);
    plan(3, CtlEn | cpt_pkg::PrescDiv1, 16'hFF00);
    load_plan();
    quiet = 1'b1;
    while (sb.ever_wrapped != '1) send_tick(4'd15);
    quiet = 1'b0;

    // Full cascade chain with irqs; timer 0 carries a cascade bit it ignores.
    plan(0, CtlEn | CtlIrq | CtlCasc | cpt_pkg::PrescDiv1, 16'hFFFF);
    plan(1, CtlEn | CtlCasc | CtlIrq, 16'hFFFF);
    plan(2, CtlEn | CtlCasc | CtlIrq, 16'hFFFE);
    plan(3, 8'hFF, 16'hFFFF);
    load_plan();
    send_tick(4'd15);
    send_tick(4'd1);
    send_tick(4'd0);
    send_tick(4'd15);

    // Park timer 0 on the slowest prescaler to build a leftover...
    plan(0, CtlEn | CtlIrq | cpt_pkg::PrescDiv1024, 16'hFFFF);
    load_plan();
    repeat (4) send_tick(4'd15);

    // ...then drop to divide-by-one: far more than 15 overflows in one tick,
    // saturating every wraps field down the chain.
    plan(0, CtlEn | CtlIrq | cpt_pkg::PrescDiv1, 16'hFFFF);
    load_plan();
    send_tick(4'd15);
    send_tick(4'd0);

    // Random phases: random control bytes, mostly enabled, with reloads near
    // the top so overflows keep coming. The last phases use arbitrary reloads.
    random_sent = 0;
    while (random_sent < RandomItems) begin
      any_reload = (random_sent + 60 >= RandomItems);
      for (int t = 0; t < cpt_pkg::NumTimers; t++) begin
        c = 8'($urandom);
        if ($urandom_range(0, 3) != 0) c[cpt_pkg::CtlEnableBit] = 1'b1;
        if (any_reload) r = 16'($urandom);
        else if ($urandom_range(0, 7) == 0) r = 16'hFFFF;
        else r = 16'hFFFF - 16'($urandom_range(0, 63));
        plan(t, c, r);
      end
      load_plan();
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(5, 40);
      repeat (n) send_tick(4'($urandom_range(0, 15)));
      random_sent += n;
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
